/* sv/b58sd_pkg.sv */
package b58sd_pkg;

	localparam int MAX_DIGITS_DEF   = 10;
	localparam int PROBE_DIGITS_DEF = 3;
	localparam int CNT_W            = 4;
	localparam int VAL_W            = 59;
	localparam int PROBE_W          = 18;
	localparam int DIGIT_W          = 6;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_PREFIX    = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LONG  = 3'd3,
		ST_BAD_CHAR  = 3'd4
	} status_t;

	typedef struct packed {
		logic               ok;
		logic [DIGIT_W-1:0] value;
	} digit_t;

	typedef struct packed {
		status_t            status;
		logic [VAL_W-1:0]   modulus;
		logic [VAL_W-1:0]   remainder;
		logic [PROBE_W-1:0] probe_target;
	} result_t;

	// 58 to the power p, reduced to the width of the probe output.
	function automatic logic [PROBE_W-1:0] probe_mod(input int p);
		longint acc;
		acc = 1;
		for (int i = 0; i < 10; i++) begin
			if (i < p) begin
				acc = (acc * 58) & ((longint'(1) << PROBE_W) - longint'(1));
			end
		end
		return PROBE_W'(acc);
	endfunction

endpackage

/* sv/base58_suffix_decoder.sv */
// Channel | Direction | Handshake           | Beat payload
// input   | in        | in_valid, in_stall   | char_code, is_last, no_char, prefix_given
// output  | out       | out_valid, out_stall | status, modulus, remainder, probe_target
//
// A beat is registered on entry and folded into the running value when it leaves
// that register, which also loads a final beat's result into the output register.
// One beat is taken per cycle unless a final beat stalls; the sole feedback is the fold.
// Reset clears the valid flags and the accumulators; a result also returns them to reset.
// A stalled result only holds back a final beat; other beats keep flowing past it.
module base58_suffix_decoder #(
	parameter int MAX_DIGITS   = b58sd_pkg::MAX_DIGITS_DEF,
	parameter int PROBE_DIGITS = b58sd_pkg::PROBE_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	input  logic        no_char,
	input  logic        prefix_given,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [58:0] modulus,
	output logic [58:0] remainder,
	output logic [17:0] probe_target
);

	logic               valid_s1;
	logic [7:0]         char_s1;
	logic               last_s1;
	logic               none_s1;
	logic               prefix_s1;
	logic               go_s1;
	logic               in_go;
	logic               out_valid_q;
	b58sd_pkg::digit_t  digit;
	b58sd_pkg::result_t res;
	b58sd_pkg::result_t res_q;

	assign go_s1    = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go_s1;
	assign in_go    = in_valid && !in_stall;

	b58sd_digit_map u_map (
		.char_code (char_s1),
		.digit     (digit)
	);

	b58sd_accum #(
		.MAX_DIGITS   (MAX_DIGITS),
		.PROBE_DIGITS (PROBE_DIGITS)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go_s1),
		.is_last      (last_s1),
		.no_char      (none_s1),
		.prefix_given (prefix_s1),
		.digit        (digit),
		.result       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_go) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			char_s1   <= char_code;
			last_s1   <= is_last;
			none_s1   <= no_char;
			prefix_s1 <= prefix_given;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign modulus      = res_q.modulus;
	assign remainder    = res_q.remainder;
	assign probe_target = res_q.probe_target;

endmodule

/* sv/b58sd_digit_map.sv */
module b58sd_digit_map (
	input  logic [7:0]       char_code,
	output b58sd_pkg::digit_t digit
);

	logic [7:0] offs;

	always_comb begin
		digit.ok = 1'b1;
		offs     = 8'h00;
		priority if (char_code >= 8'h31 && char_code <= 8'h39) begin
			offs = 8'h31;
		end else if (char_code >= 8'h41 && char_code <= 8'h48) begin
			offs = 8'h41 - 8'd9;
		end else if (char_code >= 8'h4a && char_code <= 8'h4e) begin
			offs = 8'h4a - 8'd17;
		end else if (char_code >= 8'h50 && char_code <= 8'h5a) begin
			offs = 8'h50 - 8'd22;
		end else if (char_code >= 8'h61 && char_code <= 8'h6b) begin
			offs = 8'h61 - 8'd33;
		end else if (char_code >= 8'h6d && char_code <= 8'h7a) begin
			offs = 8'h6d - 8'd44;
		end else begin
			digit.ok = 1'b0;
			offs     = char_code;
		end
		digit.value = b58sd_pkg::DIGIT_W'(char_code - offs);
	end

endmodule

/* sv/b58sd_accum.sv */
module b58sd_accum #(
	parameter int MAX_DIGITS   = b58sd_pkg::MAX_DIGITS_DEF,
	parameter int PROBE_DIGITS = b58sd_pkg::PROBE_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic                is_last,
	input  logic                no_char,
	input  logic                prefix_given,
	input  b58sd_pkg::digit_t   digit,
	output b58sd_pkg::result_t  result
);

	localparam int CW = b58sd_pkg::CNT_W;
	localparam int VW = b58sd_pkg::VAL_W;
	localparam int PW = b58sd_pkg::PROBE_W;
	localparam int DW = b58sd_pkg::DIGIT_W;
	localparam logic [PW-1:0] PROBE_MOD = b58sd_pkg::probe_mod(PROBE_DIGITS);

	logic [CW-1:0] count_q, count_n;
	logic [VW-1:0] mod_q, mod_n;
	logic [VW-1:0] val_q, val_n;
	logic [PW-1:0] probe_q, probe_n;
	logic          bad_q, bad_n;
	logic [DW-1:0] hist_q [PROBE_DIGITS];
	logic [DW-1:0] hist_n [PROBE_DIGITS];
	logic          fold;

	assign fold = !no_char && digit.ok && (count_q < CW'(MAX_DIGITS));

	always_comb begin
		count_n = count_q;
		mod_n   = mod_q;
		val_n   = val_q;
		probe_n = probe_q;
		bad_n   = bad_q | (!no_char && !digit.ok);
		hist_n  = hist_q;
		if (!no_char && count_q <= CW'(MAX_DIGITS)) begin
			count_n = count_q + CW'(1);
		end
		if (fold) begin
			mod_n   = (mod_q << 6) - (mod_q << 2) - (mod_q << 1);
			val_n   = (val_q << 6) - (val_q << 2) - (val_q << 1) + VW'(digit.value);
			// The oldest kept digit leaves the window of the last few digits.
			probe_n = (probe_q << 6) - (probe_q << 2) - (probe_q << 1)
				+ PW'(digit.value)
				- PW'(PW'(hist_q[PROBE_DIGITS-1]) * PROBE_MOD);
			hist_n[0] = digit.value;
			for (int i = 1; i < PROBE_DIGITS; i++) begin
				hist_n[i] = hist_q[i-1];
			end
		end
	end

	always_comb begin
		priority if (prefix_given) begin
			result.status = b58sd_pkg::ST_PREFIX;
		end else if (count_n == '0) begin
			result.status = b58sd_pkg::ST_EMPTY;
		end else if (count_n > CW'(MAX_DIGITS)) begin
			result.status = b58sd_pkg::ST_TOO_LONG;
		end else if (bad_n) begin
			result.status = b58sd_pkg::ST_BAD_CHAR;
		end else begin
			result.status = b58sd_pkg::ST_OK;
		end
		if (result.status == b58sd_pkg::ST_OK) begin
			result.modulus      = mod_n;
			result.remainder    = val_n;
			result.probe_target = probe_n;
		end else begin
			result.modulus      = '0;
			result.remainder    = '0;
			result.probe_target = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mod_q   <= VW'(1);
			val_q   <= '0;
			probe_q <= '0;
			bad_q   <= 1'b0;
			for (int i = 0; i < PROBE_DIGITS; i++) begin
				hist_q[i] <= '0;
			end
		end else if (go) begin
			if (is_last) begin
				count_q <= '0;
				mod_q   <= VW'(1);
				val_q   <= '0;
				probe_q <= '0;
				bad_q   <= 1'b0;
				for (int i = 0; i < PROBE_DIGITS; i++) begin
					hist_q[i] <= '0;
				end
			end else begin
				count_q <= count_n;
				mod_q   <= mod_n;
				val_q   <= val_n;
				probe_q <= probe_n;
				bad_q   <= bad_n;
				hist_q  <= hist_n;
			end
		end
	end

endmodule

/* tb/sv/suffix_result_checker.sv */
module suffix_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	input  logic        no_char,
	input  logic        prefix_given,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [58:0] modulus,
	input  logic [58:0] remainder,
	input  logic [17:0] probe_target,
	output int          pending,
	output int          errors
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint PROBE_MOD = 58 ** b58sd_pkg::PROBE_DIGITS_DEF;

	logic [b58sd_pkg::CNT_W-1:0]   digit_count;
	logic [b58sd_pkg::VAL_W-1:0]   modulus_acc;
	logic [b58sd_pkg::VAL_W-1:0]   value_acc;
	logic [b58sd_pkg::PROBE_W-1:0] probe_acc;
	logic                          bad_seen;
	b58sd_pkg::result_t            expected_results[$];
	int                            mismatches = 0;

	function automatic void clear_suffix();
		digit_count = '0;
		modulus_acc = b58sd_pkg::VAL_W'(1);
		value_acc   = '0;
		probe_acc   = '0;
		bad_seen    = 1'b0;
	endfunction

	function automatic b58sd_pkg::digit_t b58_digit(input logic [7:0] c);
		b58sd_pkg::digit_t d;
		d.ok = 1'b1;
		d.value = '0;
		if (c >= "1" && c <= "9") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "1");
		end else if (c >= "A" && c <= "H") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "A" + 8'd9);
		end else if (c >= "J" && c <= "N") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "J" + 8'd17);
		end else if (c >= "P" && c <= "Z") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "P" + 8'd22);
		end else if (c >= "a" && c <= "k") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "a" + 8'd33);
		end else if (c >= "m" && c <= "z") begin
			d.value = b58sd_pkg::DIGIT_W'(c - "m" + 8'd44);
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	// Folds one beat into the running suffix value; returns 1 when the beat closes the suffix.
	function automatic bit fold_beat(input logic [7:0] c, input logic last, input logic none,
			input logic pre, output b58sd_pkg::result_t res);
		b58sd_pkg::digit_t d;
		res = '0;
		if (!none) begin
			d = b58_digit(c);
			if (!d.ok) begin
				bad_seen = 1'b1;
			end
			if (digit_count < b58sd_pkg::MAX_DIGITS_DEF && d.ok) begin
				modulus_acc = modulus_acc * b58sd_pkg::VAL_W'(58);
				value_acc = value_acc * b58sd_pkg::VAL_W'(58) + b58sd_pkg::VAL_W'(d.value);
				probe_acc = b58sd_pkg::PROBE_W'(value_acc % b58sd_pkg::VAL_W'(PROBE_MOD));
			end
			if (digit_count <= b58sd_pkg::MAX_DIGITS_DEF) begin
				digit_count = digit_count + 1'b1;
			end
		end
		if (!last) begin
			return 1'b0;
		end
		if (pre) begin
			res.status = b58sd_pkg::ST_PREFIX;
		end else if (digit_count == 0) begin
			res.status = b58sd_pkg::ST_EMPTY;
		end else if (digit_count > b58sd_pkg::MAX_DIGITS_DEF) begin
			res.status = b58sd_pkg::ST_TOO_LONG;
		end else if (bad_seen) begin
			res.status = b58sd_pkg::ST_BAD_CHAR;
		end else begin
			res.status = b58sd_pkg::ST_OK;
			res.modulus = modulus_acc;
			res.remainder = value_acc;
			res.probe_target = probe_acc;
		end
		clear_suffix();
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		b58sd_pkg::result_t want;
		b58sd_pkg::result_t pred;
		if (!arst_n) begin
			clear_suffix();
			expected_results.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d", $time, status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, got %0d", $time, want.status, status);
						mismatches++;
					end
					if (modulus !== want.modulus) begin
						$display("%0t: modulus expected %0d, got %0d", $time, want.modulus,
							modulus);
						mismatches++;
					end
					if (remainder !== want.remainder) begin
						$display("%0t: remainder expected %0d, got %0d", $time, want.remainder,
							remainder);
						mismatches++;
					end
					if (probe_target !== want.probe_target) begin
						$display("%0t: probe_target expected %0d, got %0d", $time,
							want.probe_target, probe_target);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (fold_beat(char_code, is_last, no_char, prefix_given, pred)) begin
					expected_results.push_back(pred);
				end
			end
		end
		pending <= expected_results.size();
		errors <= mismatches;
	end

endmodule

/* tb/sv/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BEAT_TARGET    = 1950;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = '0;
	logic        is_last = 1'b0;
	logic        no_char = 1'b0;
	logic        prefix_given = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [58:0] modulus;
	logic [58:0] remainder;
	logic [17:0] probe_target;

	int pending;
	int errors;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	string b58_alpha = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

	base58_suffix_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.is_last(is_last),
		.no_char(no_char),
		.prefix_given(prefix_given),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.modulus(modulus),
		.remainder(remainder),
		.probe_target(probe_target)
	);

	suffix_result_checker result_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.is_last(is_last),
		.no_char(no_char),
		.prefix_given(prefix_given),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.modulus(modulus),
		.remainder(remainder),
		.probe_target(probe_target),
		.pending(pending),
		.errors(errors)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_reqs) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_char();
		if ($urandom_range(99) < 7) begin
			return 8'($urandom());
		end
		return 8'(b58_alpha[$urandom_range(57)]);
	endfunction

	task automatic send_beat(input logic [7:0] c, input logic last, input logic none,
			input logic pre);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		is_last <= last;
		no_char <= none;
		prefix_given <= pre;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		beats_sent++;
	endtask

	task automatic send_text(input string s, input logic pre);
		for (int i = 0; i < s.len(); i++) begin
			send_beat(8'(s[i]), i == s.len() - 1, 1'b0, pre);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int len;
		int r;
		int quarter_end;
		logic pre;
		logic tail_empty;
		logic closes;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(8'h00, 1'b1, 1'b1, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b1, 1'b1);
		send_text("1", 1'b0);
		send_beat(8'h00, 1'b1, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b1, 1'b1);
		send_text("A", 1'b0);
		send_text("zzzzzzzzzz", 1'b0);
		send_text("2222222222O", 1'b1);
		wait_drained();

		// Results are held back long enough for the decoder to fill and stall its input.
		hold_reqs++;
		repeat (40) begin
			send_beat(pick_char(), 1'b1, 1'b0, 1'b0);
		end
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 55; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 55; end
				default: begin send_idle_pct = 8; stall_pct = 8; end
			endcase
			quarter_end = beats_sent + (BEAT_TARGET - beats_sent) / (4 - ph);
			while (beats_sent < quarter_end) begin
				r = $urandom_range(99);
				if (r < 5) begin
					len = 0;
				end else if (r < 12) begin
					len = $urandom_range(14, 11);
				end else begin
					len = $urandom_range(10, 1);
				end
				pre = ($urandom_range(9) == 0);
				tail_empty = (len == 0) || ($urandom_range(4) == 0);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(19) == 0) begin
						send_beat(8'($urandom()), 1'b0, 1'b1, 1'($urandom_range(1)));
					end
					closes = !tail_empty && (i == len - 1);
					send_beat(pick_char(), closes, 1'b0, closes ? pre : 1'($urandom_range(1)));
				end
				if (tail_empty) begin
					send_beat(8'($urandom()), 1'b1, 1'b1, pre);
				end
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
